// ===== rtl/dwr_pkg.sv =====
`timescale 1ns / 1ps

package dwr_pkg;

	localparam int RV_W      = 31;
	localparam int VAL_W     = 8;
	localparam int DIV_CNT_W = $clog2(RV_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RV_W - 1);

	typedef enum logic {
		KIND_DRAW  = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [RV_W-1:0]   random_value;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0]  drawn_value;
		logic [VAL_W-1:0]  drawn_count;
		logic              exhausted;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic exhaust;
		logic div_step;
		logic walk_step;
		logic mark;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_empty;
		logic div_last;
		logic found;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== rtl/dwr_ctrl.sv =====
`timescale 1ns / 1ps

module dwr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dwr_pkg::dp_status_t status,
	output dwr_pkg::dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_WALK  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.is_clear) begin
					cmd.clear = 1'b1;
					state_nxt = ST_DONE;
				end else if (status.is_empty) begin
					cmd.exhaust = 1'b1;
					state_nxt   = ST_DONE;
				end else begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.found) begin
					cmd.mark  = 1'b1;
					state_nxt = ST_DONE;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_DONE: begin
				// hold the result until the output register can take it
				if (!status.out_busy) begin
					cmd.push  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/dwr_dp.sv =====
`timescale 1ns / 1ps

module dwr_dp #(
	parameter int POOL_SIZE = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dwr_pkg::in_item_t   in_data,
	input  dwr_pkg::dp_cmd_t    cmd,
	input  logic                out_ready,
	output dwr_pkg::dp_status_t status,
	output logic                out_valid,
	output dwr_pkg::out_item_t  out_data
);

	localparam int CW = $clog2(POOL_SIZE + 1);
	localparam int IW = $clog2(POOL_SIZE);
	localparam logic [CW-1:0] POOL_N = CW'(POOL_SIZE);

	dwr_pkg::kind_t                   kind_q;
	logic [dwr_pkg::RV_W-1:0]         rv_q;
	logic [dwr_pkg::DIV_CNT_W-1:0]    bit_cnt_q;
	logic [CW-1:0]                    rem_q;
	logic [IW-1:0]                    idx_q;
	logic [POOL_SIZE-1:0]             used_q;
	logic [CW-1:0]                    total_q;
	dwr_pkg::out_item_t               res_q;
	dwr_pkg::out_item_t               out_q;
	logic                             out_valid_q;

	logic [CW-1:0] free_cnt;
	logic [CW:0]   rem_sh;
	logic [CW:0]   free_x;
	logic [CW-1:0] rem_nxt;
	logic [CW-1:0] slot_num;
	logic [CW-1:0] total_inc;
	logic          slot_free;

	assign free_cnt  = POOL_N - total_q;
	assign rem_sh    = {rem_q, rv_q[dwr_pkg::RV_W-1]};
	assign free_x    = {1'b0, free_cnt};
	assign rem_nxt   = (rem_sh >= free_x) ? CW'(rem_sh - free_x) : rem_sh[CW-1:0];
	assign slot_num  = CW'(idx_q) + CW'(1);
	assign total_inc = total_q + CW'(1);
	assign slot_free = !used_q[idx_q];

	assign status.is_clear = (kind_q == dwr_pkg::KIND_CLEAR);
	assign status.is_empty = (total_q >= POOL_N);
	assign status.div_last = (bit_cnt_q == dwr_pkg::DIV_LAST);
	// rem_q doubles as the rank countdown during the walk
	assign status.found    = slot_free && (rem_q == '0);
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// item capture, bit-serial remainder, slot walk, staged result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= in_data.kind;
			rv_q      <= in_data.random_value;
			bit_cnt_q <= '0;
			rem_q     <= '0;
			idx_q     <= '0;
		end
		if (cmd.div_step) begin
			rem_q     <= rem_nxt;
			rv_q      <= {rv_q[dwr_pkg::RV_W-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q + dwr_pkg::DIV_CNT_W'(1);
		end
		if (cmd.walk_step) begin
			if (slot_free) begin
				rem_q <= rem_q - CW'(1);
			end
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.clear) begin
			res_q <= '0;
		end
		if (cmd.exhaust) begin
			res_q.drawn_value <= '0;
			res_q.drawn_count <= dwr_pkg::VAL_W'(total_q);
			res_q.exhausted   <= 1'b1;
		end
		if (cmd.mark) begin
			res_q.drawn_value <= dwr_pkg::VAL_W'(slot_num);
			res_q.drawn_count <= dwr_pkg::VAL_W'(total_inc);
			res_q.exhausted   <= 1'b0;
		end
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				used_q  <= '0;
				total_q <= '0;
			end else if (cmd.mark) begin
				used_q[idx_q] <= 1'b1;
				total_q       <= total_inc;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_mark_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark |-> slot_free)
		else $error("marking a slot that is already used");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= POOL_N)
		else $error("drawn count above pool size");

	a_mark_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark |=> total_q == $past(total_inc))
		else $error("draw did not advance the count");

	a_push_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending item");

endmodule

// ===== rtl/draw_without_replacement_core.sv =====
`timescale 1ns / 1ps

// Draws tokens 1..POOL_SIZE without replacement. Each input item gives exactly one result
// item. A clear item empties the pool and answers 0/0/0; reset empties it too, at once.
// A draw from an empty pool changes nothing and answers drawn_value 0, the current count
// and exhausted 1. A draw reduces random_value modulo the free-token count with a
// bit-serial remainder unit, then walks the used map one slot per cycle up to the chosen
// free slot. One item is worked at a time; the next item is accepted while the previous
// result still waits in the output register.
module draw_without_replacement_core #(
	parameter int POOL_SIZE = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dwr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output dwr_pkg::out_item_t out_data
);

	dwr_pkg::dp_cmd_t    cmd;
	dwr_pkg::dp_status_t status;

	dwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	dwr_dp #(
		.POOL_SIZE (POOL_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_ready (out_ready),
		.status    (status),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int POOL = 128;
	localparam int RANDOM_ITEMS = 1760;
	localparam int TAIL_CYCLES = 40 + 2 * POOL;

	typedef struct {
		dwr_pkg::kind_t           kind;
		logic [dwr_pkg::RV_W-1:0] rv;
		int                       reps;
		bit                       typed;
		dwr_pkg::out_item_t       res;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	dwr_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	dwr_pkg::out_item_t out_data;

	// shadow of the pool, updated when an item is accepted
	bit [POOL-1:0] taken_map;
	int unsigned   taken_cnt;

	dwr_pkg::out_item_t expected_tokens[$];
	int        mismatches;
	int        results_checked;
	int        draws_sent;
	int        clears_sent;
	int        empty_draws;
	int        pools_emptied;
	bit        calm;

	stim_row_t plan[14];

	draw_without_replacement_core #(
		.POOL_SIZE(POOL)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("[draw_without_replacement_core] ERROR");
		$finish;
	end

	function automatic dwr_pkg::out_item_t draw_outcome(dwr_pkg::in_item_t it);
		dwr_pkg::out_item_t r;
		int unsigned free_cnt;
		int unsigned rank;
		int          chosen;
		int          s;
		r = '0;
		if (it.kind == dwr_pkg::KIND_CLEAR) begin
			taken_map = '0;
			taken_cnt = 0;
		end else if (taken_cnt >= POOL) begin
			r.exhausted = 1'b1;
		end else begin
			free_cnt = POOL - taken_cnt;
			rank = it.random_value % free_cnt;
			chosen = -1;
			for (s = 0; s < POOL && chosen < 0; s++) begin
				if (!taken_map[s]) begin
					if (rank == 0)
						chosen = s;
					else
						rank--;
				end
			end
			taken_map[chosen] = 1'b1;
			taken_cnt++;
			r.drawn_value = dwr_pkg::VAL_W'(chosen + 1);
			if (taken_cnt == POOL)
				pools_emptied++;
		end
		r.drawn_count = dwr_pkg::VAL_W'(taken_cnt);
		return r;
	endfunction

	task automatic send_item(dwr_pkg::in_item_t it, bit typed, dwr_pkg::out_item_t res);
		dwr_pkg::out_item_t predicted;
		@(negedge clk);
		if (!calm && $urandom_range(99) < 35) begin
			in_valid = 1'b0;
			repeat ($urandom_range(70, 8)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
		predicted = draw_outcome(it);
		expected_tokens.push_back(typed ? res : predicted);
		if (it.kind == dwr_pkg::KIND_CLEAR)
			clears_sent++;
		else
			draws_sent++;
	endtask

	// random stalls on the result side, in bursts
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && arst_n && $urandom_range(999) < 25) begin
				out_ready = 1'b0;
				repeat ($urandom_range(10, 1)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		dwr_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item value %0d count %0d exhausted %0d", $time,
					out_data.drawn_value, out_data.drawn_count, out_data.exhausted);
			end else begin
				want = expected_tokens.pop_front();
				results_checked++;
				if (want.exhausted)
					empty_draws++;
				if (out_data.drawn_value !== want.drawn_value) begin
					mismatches++;
					$display("%0t: drawn_value expected %0d got %0d", $time,
						want.drawn_value, out_data.drawn_value);
				end
				if (out_data.drawn_count !== want.drawn_count) begin
					mismatches++;
					$display("%0t: drawn_count expected %0d got %0d", $time,
						want.drawn_count, out_data.drawn_count);
				end
				if (out_data.exhausted !== want.exhausted) begin
					mismatches++;
					$display("%0t: exhausted expected %0d got %0d", $time,
						want.exhausted, out_data.exhausted);
				end
			end
		end
	end

	initial begin
		dwr_pkg::in_item_t it;
		int unsigned free_cnt;
		int          r;
		int          i;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		taken_map = '0;
		taken_cnt = 0;
		mismatches = 0;
		results_checked = 0;
		draws_sent = 0;
		clears_sent = 0;
		empty_draws = 0;
		pools_emptied = 0;

		plan = '{
			'{dwr_pkg::KIND_DRAW,  31'd0,        1,   1'b1, '{8'd1,   8'd1,   1'b0}},
			'{dwr_pkg::KIND_DRAW,  31'h7FFFFFFF, 1,   1'b0, '0},
			'{dwr_pkg::KIND_CLEAR, 31'h7FFFFFFF, 1,   1'b1, '{8'd0,   8'd0,   1'b0}},
			'{dwr_pkg::KIND_CLEAR, 31'd0,        1,   1'b1, '{8'd0,   8'd0,   1'b0}},
			'{dwr_pkg::KIND_DRAW,  31'd127,      1,   1'b1, '{8'd128, 8'd1,   1'b0}},
			'{dwr_pkg::KIND_DRAW,  31'd0,        1,   1'b1, '{8'd1,   8'd2,   1'b0}},
			'{dwr_pkg::KIND_DRAW,  31'd126,      1,   1'b0, '0},
			'{dwr_pkg::KIND_DRAW,  31'h2AAAAAAA, 1,   1'b0, '0},
			'{dwr_pkg::KIND_DRAW,  31'h55555555, 1,   1'b0, '0},
			// fill the pool to the last token
			'{dwr_pkg::KIND_DRAW,  31'h7FFFFFFF, 123, 1'b0, '0},
			'{dwr_pkg::KIND_DRAW,  31'd0,        1,   1'b1, '{8'd0,   8'd128, 1'b1}},
			'{dwr_pkg::KIND_DRAW,  31'h7FFFFFFF, 1,   1'b1, '{8'd0,   8'd128, 1'b1}},
			'{dwr_pkg::KIND_CLEAR, 31'd0,        1,   1'b1, '{8'd0,   8'd0,   1'b0}},
			'{dwr_pkg::KIND_DRAW,  31'd0,        1,   1'b1, '{8'd1,   8'd1,   1'b0}}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[p]) begin
			for (r = 0; r < plan[p].reps; r++) begin
				it.kind = plan[p].kind;
				it.random_value = plan[p].rv;
				send_item(it, plan[p].typed, plan[p].res);
			end
		end

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 700 && i < 1000);
			// mostly run pools dry; clear soon after they run out
			if (taken_cnt >= POOL)
				it.kind = ($urandom_range(99) < 45) ? dwr_pkg::KIND_CLEAR : dwr_pkg::KIND_DRAW;
			else
				it.kind = ($urandom_range(199) == 0) ? dwr_pkg::KIND_CLEAR : dwr_pkg::KIND_DRAW;
			free_cnt = (taken_cnt >= POOL) ? 1 : POOL - taken_cnt;
			case ($urandom_range(5))
				0, 5: it.random_value = dwr_pkg::RV_W'($urandom);
				1: it.random_value = '0;
				2: it.random_value = '1;
				3: it.random_value = dwr_pkg::RV_W'($urandom_range(free_cnt - 1, 0));
				default: it.random_value =
					dwr_pkg::RV_W'(free_cnt * $urandom_range(1000, 1) - $urandom_range(1, 0));
			endcase
			send_item(it, 1'b0, '0);
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid = 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d draws (%0d on an empty pool), %0d clears, %0d results checked",
			draws_sent, empty_draws, clears_sent, results_checked);
		$display("pool drawn down to the last token %0d times", pools_emptied);
		if (mismatches == 0 && expected_tokens.size() == 0) begin
			$display("[draw_without_replacement_core] OK");
		end else begin
			$display("[draw_without_replacement_core] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dwr_pkg.sv
rtl/dwr_ctrl.sv
rtl/dwr_dp.sv
rtl/draw_without_replacement_core.sv
tb/tb_top.sv
